/* hdl/set_assoc_lru_cache_sim_core_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared immediate-style wrappers for concurrent checks, clocked on clk and
// disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef SET_ASSOC_LRU_CACHE_SIM_CORE_MACROS_SVH
`define SET_ASSOC_LRU_CACHE_SIM_CORE_MACROS_SVH

// same-cycle implication
`define SALC_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("salc check failed");

// next-cycle implication
`define SALC_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("salc check failed");

`endif

/* hdl/salc_pkg.sv */
// ----------------------------------------------------------------------------
// salc_pkg
// Types and constants shared by the set-associative LRU cache model core.
// ----------------------------------------------------------------------------
package salc_pkg;

	localparam int ADDR_W  = 32;
	localparam int TAG_W   = 32;
	localparam int AGE_W   = 3;
	localparam int CNT_W32 = 32;

	localparam logic [AGE_W-1:0] AGE_TOP = 3'd7;

	// access kinds; anything but modify behaves as a load here
	localparam logic [1:0] OP_LOAD   = 2'd0;
	localparam logic [1:0] OP_STORE  = 2'd1;
	localparam logic [1:0] OP_MODIFY = 2'd2;

	// register indexes on the config port (paddr[3:2])
	localparam logic [1:0] REG_SET_BITS = 2'd0;
	localparam logic [1:0] REG_OFS_BITS = 2'd1;
	localparam logic [1:0] REG_WAYS     = 2'd2;

	localparam logic [2:0] RST_SET_BITS = 3'd4;
	localparam logic [4:0] RST_OFS_BITS = 5'd4;
	localparam logic [3:0] RST_WAYS     = 4'd1;

	typedef struct packed {
		logic              valid;
		logic [AGE_W-1:0]  age;
		logic [TAG_W-1:0]  tag;
	} line_t;

	typedef struct packed {
		logic [2:0] set_index_bits;
		logic [4:0] block_offset_bits;
		logic [3:0] ways_in_use;
	} cfg_t;

endpackage

/* hdl/salc_regs.sv */
// ----------------------------------------------------------------------------
// salc_regs
// APB register file: set bits, block offset bits, ways in use.
// ----------------------------------------------------------------------------
module salc_regs (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	output salc_pkg::cfg_t     cfg
);
	import salc_pkg::*;

	cfg_t       cfg_q;
	logic       wr_stb;
	logic [1:0] reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign wr_stb  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.set_index_bits    <= RST_SET_BITS;
			cfg_q.block_offset_bits <= RST_OFS_BITS;
			cfg_q.ways_in_use       <= RST_WAYS;
		end else if (wr_stb) begin
			unique case (reg_idx)
				REG_SET_BITS: cfg_q.set_index_bits    <= pwdata[2:0];
				REG_OFS_BITS: cfg_q.block_offset_bits <= pwdata[4:0];
				REG_WAYS:     cfg_q.ways_in_use       <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_SET_BITS: prdata = {29'd0, cfg_q.set_index_bits};
			REG_OFS_BITS: prdata = {27'd0, cfg_q.block_offset_bits};
			REG_WAYS:     prdata = {28'd0, cfg_q.ways_in_use};
			default:      prdata = 32'd0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

/* hdl/salc_mem.sv */
// ----------------------------------------------------------------------------
// salc_mem
// Set memory, one row per set holding every way. A per-row init flag,
// cleared by reset, makes never-written rows read as all zero.
// ----------------------------------------------------------------------------
module salc_mem #(
	parameter int MAX_SET_BITS = 6,
	parameter int MAX_WAYS     = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                rd_en,
	input  logic [MAX_SET_BITS-1:0]             rd_addr,
	output salc_pkg::line_t [MAX_WAYS-1:0]      rd_row,
	input  logic                                wr_en,
	input  logic [MAX_SET_BITS-1:0]             wr_addr,
	input  salc_pkg::line_t [MAX_WAYS-1:0]      wr_row
);
	import salc_pkg::*;

	localparam int DEPTH = 1 << MAX_SET_BITS;

	line_t [MAX_WAYS-1:0] mem_q [DEPTH];
	line_t [MAX_WAYS-1:0] rd_row_q;
	logic  [DEPTH-1:0]    init_q;
	logic                 rd_init_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_row;
		end
		if (rd_en) begin
			rd_row_q <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q    <= '0;
			rd_init_q <= 1'b0;
		end else begin
			if (wr_en) begin
				init_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_init_q <= init_q[rd_addr];
			end
		end
	end

	assign rd_row = rd_init_q ? rd_row_q : '0;

endmodule

/* hdl/salc_engine.sv */
// ----------------------------------------------------------------------------
// salc_engine
// Access sequencer: decode, set read, way-by-way scan through one shared
// tag/age compare unit, LRU update and write-back, saturating totals.
// ----------------------------------------------------------------------------
`include "set_assoc_lru_cache_sim_core_macros.svh"

module salc_engine #(
	parameter int MAX_SET_BITS = 6,
	parameter int MAX_WAYS     = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  salc_pkg::cfg_t                      cfg,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [1:0]                          in_op,
	input  logic [31:0]                         in_address,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [1:0]                          out_hits,
	output logic                                out_missed,
	output logic                                out_evicted,
	output logic [31:0]                         out_total_hits,
	output logic [31:0]                         out_total_misses,
	output logic [31:0]                         out_total_evictions,
	output logic                                rd_en,
	output logic [MAX_SET_BITS-1:0]             rd_addr,
	input  salc_pkg::line_t [MAX_WAYS-1:0]      rd_row,
	output logic                                wr_en,
	output logic [MAX_SET_BITS-1:0]             wr_addr,
	output salc_pkg::line_t [MAX_WAYS-1:0]      wr_row
);
	import salc_pkg::*;

	localparam int SET_W = MAX_SET_BITS;
	localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int CNT_W = $clog2(MAX_WAYS + 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RD   = 2'd1;
	localparam logic [1:0] ST_SCAN = 2'd2;
	localparam logic [1:0] ST_UPD  = 2'd3;

	logic [1:0]       state_q;
	logic             accept;
	logic             commit;

	// decoded access
	logic [1:0]       op_q;
	logic [SET_W-1:0] set_q;
	logic [TAG_W-1:0] tag_q;
	logic [CNT_W-1:0] ways_q;

	// decode
	logic [3:0]       sbits;
	logic [5:0]       tag_sh;
	logic [SET_W-1:0] set_mask;
	logic [SET_W-1:0] set_d;
	logic [TAG_W-1:0] tag_d;
	logic [4:0]       ways_ext;
	logic [CNT_W-1:0] ways_d;

	// scan results
	logic [WAY_W-1:0] way_q;
	logic             hit_fnd_q, free_fnd_q, old_fnd_q;
	logic [WAY_W-1:0] hit_way_q, free_way_q, old_way_q;
	logic [AGE_W-1:0] hit_age_q, old_age_q;
	line_t            cur;
	logic             scan_last;

	// update
	logic [WAY_W-1:0] tgt_way;
	line_t [MAX_WAYS-1:0] new_row;
	logic [1:0]       hits_v;
	logic             evict_v;

	logic             out_valid_q;
	logic [1:0]       out_hits_q;
	logic             out_missed_q, out_evicted_q;
	logic [31:0]      tot_hit_q, tot_miss_q, tot_evict_q;
	logic [32:0]      hit_sum, miss_sum, evict_sum;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid & in_ready;

	// address split: set = next sbits above the offset, tag = all above that
	always_comb begin
		sbits = ({1'b0, cfg.set_index_bits} > 4'(MAX_SET_BITS)) ?
			4'(MAX_SET_BITS) : {1'b0, cfg.set_index_bits};
		tag_sh   = 6'(cfg.block_offset_bits) + 6'(sbits);
		set_mask = ~({SET_W{1'b1}} << sbits);
		set_d    = SET_W'(in_address >> cfg.block_offset_bits) & set_mask;
		tag_d    = in_address >> tag_sh;
		ways_ext = {1'b0, cfg.ways_in_use};
		if (ways_ext == 5'd0) begin
			ways_d = CNT_W'(1);
		end else if (ways_ext > 5'(MAX_WAYS)) begin
			ways_d = CNT_W'(MAX_WAYS);
		end else begin
			ways_d = CNT_W'(ways_ext);
		end
	end

	assign cur       = rd_row[way_q];
	assign scan_last = (CNT_W'(way_q) + CNT_W'(1)) == ways_q;
	assign commit    = (state_q == ST_UPD) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: if (accept) state_q <= ST_RD;
				ST_RD:   state_q <= ST_SCAN;
				ST_SCAN: if (scan_last) state_q <= ST_UPD;
				ST_UPD:  if (commit) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= in_op;
			set_q  <= set_d;
			tag_q  <= tag_d;
			ways_q <= ways_d;
		end
	end

	// shared compare unit: one way per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			way_q      <= '0;
			hit_fnd_q  <= 1'b0;
			free_fnd_q <= 1'b0;
			old_fnd_q  <= 1'b0;
		end else if (accept) begin
			way_q      <= '0;
			hit_fnd_q  <= 1'b0;
			free_fnd_q <= 1'b0;
			old_fnd_q  <= 1'b0;
		end else if (state_q == ST_SCAN) begin
			if (!scan_last) begin
				way_q <= way_q + WAY_W'(1);
			end
			if (cur.valid) begin
				if (cur.tag == tag_q) begin
					if (!hit_fnd_q) begin
						hit_fnd_q <= 1'b1;
						hit_way_q <= way_q;
						hit_age_q <= cur.age;
					end
				end else if (!old_fnd_q || cur.age > old_age_q) begin
					old_fnd_q <= 1'b1;
					old_way_q <= way_q;
					old_age_q <= cur.age;
				end
			end else if (!free_fnd_q) begin
				free_fnd_q <= 1'b1;
				free_way_q <= way_q;
			end
		end
	end

	// LRU update of the whole row, each way on its own
	always_comb begin
		if (hit_fnd_q) begin
			tgt_way = hit_way_q;
		end else if (free_fnd_q) begin
			tgt_way = free_way_q;
		end else begin
			tgt_way = old_way_q;
		end
		for (int w = 0; w < MAX_WAYS; w++) begin
			new_row[w] = rd_row[w];
			if ((CNT_W'(w) < ways_q) && rd_row[w].valid && (rd_row[w].age != AGE_TOP)) begin
				if (hit_fnd_q) begin
					if (rd_row[w].age < hit_age_q) new_row[w].age = rd_row[w].age + 3'd1;
				end else if (free_fnd_q) begin
					new_row[w].age = rd_row[w].age + 3'd1;
				end else if (rd_row[w].age < old_age_q) begin
					new_row[w].age = rd_row[w].age + 3'd1;
				end
			end
		end
		new_row[tgt_way].age = '0;
		if (!hit_fnd_q) begin
			new_row[tgt_way].valid = 1'b1;
			new_row[tgt_way].tag   = tag_q;
		end
		hits_v  = {1'b0, hit_fnd_q} + ((op_q == OP_MODIFY) ? 2'd1 : 2'd0);
		evict_v = !hit_fnd_q && !free_fnd_q;
	end

	assign rd_en   = (state_q == ST_RD);
	assign rd_addr = set_q;
	assign wr_en   = commit;
	assign wr_addr = set_q;
	assign wr_row  = new_row;

	assign hit_sum   = {1'b0, tot_hit_q} + 33'(hits_v);
	assign miss_sum  = {1'b0, tot_miss_q} + 33'(!hit_fnd_q);
	assign evict_sum = {1'b0, tot_evict_q} + 33'(evict_v);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			tot_hit_q   <= '0;
			tot_miss_q  <= '0;
			tot_evict_q <= '0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
			tot_hit_q   <= hit_sum[32]   ? '1 : hit_sum[31:0];
			tot_miss_q  <= miss_sum[32]  ? '1 : miss_sum[31:0];
			tot_evict_q <= evict_sum[32] ? '1 : evict_sum[31:0];
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			out_hits_q    <= hits_v;
			out_missed_q  <= !hit_fnd_q;
			out_evicted_q <= evict_v;
		end
	end

	assign out_valid           = out_valid_q;
	assign out_hits            = out_hits_q;
	assign out_missed          = out_missed_q;
	assign out_evicted         = out_evicted_q;
	assign out_total_hits      = tot_hit_q;
	assign out_total_misses    = tot_miss_q;
	assign out_total_evictions = tot_evict_q;

	`SALC_ASSERT_IMP(a_scan_in_range, state_q == ST_SCAN, CNT_W'(way_q) < ways_q)
	`SALC_ASSERT_IMP(a_victim_known, state_q == ST_UPD && !hit_fnd_q && !free_fnd_q, old_fnd_q)
	`SALC_ASSERT_NXT(a_commit_idle, wr_en, state_q == ST_IDLE && out_valid_q)
	`SALC_ASSERT_IMP(a_hit_in_range, state_q == ST_UPD && hit_fnd_q, CNT_W'(hit_way_q) < ways_q)

endmodule

/* hdl/set_assoc_lru_cache_sim_core.sv */
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_sim_core
// Set-associative cache model with LRU replacement and hit/miss/eviction
// counting. One access per item, one result beat per access.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Beat contents (low bit first)
//  s_*      in   tuser: op[1:0]; tdata: address[31:0]
//  m_*      out  tdata: hits_this_access[1:0], missed[2], evicted[3],
//                total_hits[35:4], total_misses[67:36],
//                total_evictions[99:68], zero pad [103:100]
//  apb      cfg  0x0 set_index_bits, 0x4 block_offset_bits, 0x8 ways_in_use
//
// Sequence: accept, set read, a scan of each way in use in turn through
//   the shared tag/age comparator, then update and write-back.
// Reset: arst_n clears control, totals and the per-set init flags; sets
//   read as empty until first written, so no clearing pass is needed.
// Stalls: s_tready is high only while idle. A finished result waits in the
//   output register while the next access is taken and scanned; its
//   write-back waits until that result beat has gone.
//
module set_assoc_lru_cache_sim_core #(
	parameter int MAX_SET_BITS = 6,
	parameter int MAX_WAYS     = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	// slave stream
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [1:0]   s_tuser,	// op[1:0]
	input  logic [31:0]  s_tdata,	// address[31:0]
	// master stream: hits[1:0], missed[2], evicted[3], total_hits[35:4],
	// total_misses[67:36], total_evictions[99:68], pad
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [103:0] m_tdata,
	// config port
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [3:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);
	import salc_pkg::*;

	cfg_t                    cfg;
	logic                    rd_en, wr_en;
	logic [MAX_SET_BITS-1:0] rd_addr, wr_addr;
	line_t [MAX_WAYS-1:0]    rd_row, wr_row;

	logic [1:0]  res_hits;
	logic        res_missed, res_evicted;
	logic [31:0] res_tot_hits, res_tot_misses, res_tot_evictions;

	salc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	salc_mem #(
		.MAX_SET_BITS (MAX_SET_BITS),
		.MAX_WAYS     (MAX_WAYS)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_row  (rd_row),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_row  (wr_row)
	);

	// sequencer and shared compare unit
	salc_engine #(
		.MAX_SET_BITS (MAX_SET_BITS),
		.MAX_WAYS     (MAX_WAYS)
	) u_engine (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cfg                 (cfg),
		.in_valid            (s_tvalid),
		.in_ready            (s_tready),
		.in_op               (s_tuser),
		.in_address          (s_tdata),
		.out_valid           (m_tvalid),
		.out_ready           (m_tready),
		.out_hits            (res_hits),
		.out_missed          (res_missed),
		.out_evicted         (res_evicted),
		.out_total_hits      (res_tot_hits),
		.out_total_misses    (res_tot_misses),
		.out_total_evictions (res_tot_evictions),
		.rd_en               (rd_en),
		.rd_addr             (rd_addr),
		.rd_row              (rd_row),
		.wr_en               (wr_en),
		.wr_addr             (wr_addr),
		.wr_row              (wr_row)
	);

	assign m_tdata = {4'd0, res_tot_evictions, res_tot_misses, res_tot_hits,
		res_evicted, res_missed, res_hits};

endmodule
